/* sv/mcd_pkg.sv */
// Package for the MM:SS countdown timer with multiplexed seven-segment output.
// Holds command codes, the register reset value, the item types and the segment decode.
// No dependencies.
package mcd_pkg;

	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_SET0  = 3'd1;
	localparam logic [2:0] MODE_SET1  = 3'd2;
	localparam logic [2:0] MODE_SET2  = 3'd3;
	localparam logic [2:0] MODE_SET3  = 3'd4;
	localparam logic [2:0] MODE_START = 3'd5;
	localparam logic [2:0] MODE_PAUSE = 3'd6;
	localparam logic [2:0] MODE_ABORT = 3'd7;

	localparam logic [15:0] TPC_RESET = 16'd996;
	localparam logic [3:0]  SEC_TENS_RELOAD = 4'd5;
	localparam logic [3:0]  UNITS_RELOAD = 4'd9;

	typedef logic [3:0][3:0] digits_t;

	// one command as it enters the counter
	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] value;
	} cmd_t;

	// counter state after the current tick
	typedef struct packed {
		digits_t digits;
		logic    running;
		logic    finished;
	} cnt_view_t;

	// result item, digit_enable in the lowest bits
	typedef struct packed {
		logic       finished;
		logic       running;
		logic [6:0] segments;
		logic [3:0] digit_enable;
	} result_t;

	function automatic logic [3:0] clamp9(input logic [3:0] v);
		return (v > 4'd9) ? 4'd9 : v;
	endfunction

	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [6:0] s;
		case (clamp9(d))
			4'd0:    s = 7'd125;
			4'd1:    s = 7'd96;
			4'd2:    s = 7'd62;
			4'd3:    s = 7'd122;
			4'd4:    s = 7'd99;
			4'd5:    s = 7'd91;
			4'd6:    s = 7'd95;
			4'd7:    s = 7'd112;
			4'd8:    s = 7'd127;
			default: s = 7'd123;
		endcase
		return s;
	endfunction

endpackage

/* sv/mcd_counter.sv */
// BCD MM:SS countdown state: digit registers, run flag and tick prescaler.
// Depends on mcd_pkg.
module mcd_counter import mcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  cmd_t        cmd,
	input  logic [15:0] period,
	output cnt_view_t   view
);

	digits_t     digits_q;
	logic        run_q;
	logic [15:0] tick_q;

	digits_t     digits_n;
	logic        run_n;
	logic [15:0] tick_n;
	logic        fin;
	logic [16:0] tick_inc;
	logic [15:0] per_eff;
	logic [1:0]  set_idx;

	assign tick_inc = {1'b0, tick_q} + 17'd1;
	assign per_eff  = (period == 16'd0) ? 16'd1 : period;
	assign set_idx  = 2'(cmd.mode - MODE_SET0);

	// next state for this tick
	always_comb begin
		digits_n = digits_q;
		run_n    = run_q;
		tick_n   = tick_q;
		fin      = 1'b0;
		if (!run_q) begin
			unique case (cmd.mode) inside
				MODE_SET0, MODE_SET1, MODE_SET2, MODE_SET3: begin
					digits_n[set_idx] = clamp9(cmd.value);
				end
				MODE_START: begin
					run_n  = 1'b1;
					tick_n = 16'd0;
				end
				default: ;
			endcase
		end else if (cmd.mode == MODE_ABORT) begin
			digits_n = '0;
			run_n    = 1'b0;
			tick_n   = 16'd0;
			fin      = 1'b1;
		end else if (cmd.mode != MODE_PAUSE) begin
			if (tick_inc >= {1'b0, per_eff}) begin
				tick_n = 16'd0;
				if (digits_q == '0) begin
					run_n = 1'b0;
					fin   = 1'b1;
				end else if (digits_q[0] != 4'd0) begin
					digits_n[0] = digits_q[0] - 4'd1;
				end else if (digits_q[1] != 4'd0) begin
					digits_n[0] = UNITS_RELOAD;
					digits_n[1] = digits_q[1] - 4'd1;
				end else if (digits_q[2] != 4'd0) begin
					digits_n[0] = UNITS_RELOAD;
					digits_n[1] = SEC_TENS_RELOAD;
					digits_n[2] = digits_q[2] - 4'd1;
				end else begin
					digits_n[0] = UNITS_RELOAD;
					digits_n[1] = SEC_TENS_RELOAD;
					digits_n[2] = UNITS_RELOAD;
					digits_n[3] = digits_q[3] - 4'd1;
				end
			end else begin
				tick_n = tick_inc[15:0];
			end
		end
	end

	// commit on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			run_q    <= 1'b0;
			tick_q   <= 16'd0;
		end else if (step) begin
			digits_q <= digits_n;
			run_q    <= run_n;
			tick_q   <= tick_n;
		end
	end

	assign view.digits   = digits_n;
	assign view.running  = run_n;
	assign view.finished = fin;

endmodule

/* sv/mmss_countdown_timer_7seg_mux.sv */
// MM:SS countdown timer with a four-digit multiplexed seven-segment drive.
// Each input transfer passes the input stage register and then the result register.
// Throughput: one tick per cycle unless stalled; an input stage register and the result
// register form the pipeline, both advancing whenever the result register is free or taken.
// Reset (arst_n low, asynchronous): digits zero, idle, prescaler and mux position zero,
// ticks_per_count 996, both pipeline stages empty. Depends on mcd_pkg and mcd_counter.
module mmss_countdown_timer_7seg_mux import mcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] digit_value, [7:4] zero
	input  logic [2:0]  s_tuser,   // [2:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] digit_enable, [10:4] segments, [11] running,
	                               // [12] finished, [15:13] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // ticks_per_count
);

	logic        advance;
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic [15:0] tpc_q;
	logic [1:0]  pos_q;
	cnt_view_t   view;
	logic        step;

	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	// hold the period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpc_q <= TPC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tpc_q <= cfg_data;
		end
	end

	// capture the incoming tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.mode  <= s_tuser;
			cmd_s1.value <= s_tdata[3:0];
		end
	end

	mcd_counter u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd_s1),
		.period (tpc_q),
		.view   (view)
	);

	// advance the display position and load the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_q    <= 2'd0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2.digit_enable <= 4'd1 << pos_q;
			res_s2.segments     <= seg_of(view.digits[pos_q]);
			res_s2.running      <= view.running;
			res_s2.finished     <= view.finished;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, res_s2};

`ifndef SYNTHESIS
	a_fin_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.finished && res_s2.running))
		else $error("finished result still reports running");

	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot(res_s2.digit_enable))
		else $error("digit enable not one-hot");

	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> pos_q == $past(pos_q) + 2'd1)
		else $error("mux position did not advance on a processed tick");

	a_enable_tracks_pos: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> res_s2.digit_enable == (4'd1 << $past(pos_q)))
		else $error("digit enable does not match mux position");
`endif

endmodule
